>>> rtl/cfpq_pkg.sv
// Shared types and constants of the congestion feedback packet queue.
`default_nettype none

package cfpq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 256;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_MARK = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_MARK  = 2'd2;

   localparam logic [7:0] CAPACITY_RESET  = 8'd255;
   localparam logic [7:0] HIGH_MARK_RESET = 8'd204;
   localparam logic [7:0] LOW_MARK_RESET  = 8'd63;

   localparam logic MODE_ARRIVAL = 1'b0;
   localparam logic MODE_DONE    = 1'b1;

   localparam logic [15:0] FEEDBACK_BYTES = 16'd20;

   typedef enum logic [1:0] {
      EV_DATA   = 2'd0,
      EV_SLOW   = 2'd1,
      EV_RESUME = 2'd2,
      EV_DROP   = 2'd3
   } cfpq_event_type;

   // one stored descriptor
   typedef struct packed {
      cfpq_event_type kind;
      logic [15:0]    tag;
      logic [15:0]    bytes;
   } cfpq_entry_type;

   typedef struct packed {
      cfpq_event_type event_res;
      logic [15:0]    out_tag;
      logic [15:0]    out_bytes;
      logic [8:0]     occupancy;
   } cfpq_result_type;

   typedef struct packed {
      logic [7:0] capacity;
      logic [7:0] high_mark;
      logic [7:0] low_mark;
   } cfpq_cfg_type;

endpackage

`default_nettype wire

>>> rtl/cfpq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module cfpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/cfpq_rsp_buf.sv
// Result output register with one skid entry behind it.
`default_nettype none

module cfpq_rsp_buf
   import cfpq_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            res_valid,
   input  wire cfpq_result_type res,
   output logic                 hold_full,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output cfpq_result_type      rsp
);

   logic            out_valid_ff;
   cfpq_result_type out_ff;
   logic            hold_valid_ff;
   cfpq_result_type hold_ff;
   logic            out_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign hold_full = hold_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (hold_valid_ff) begin
            out_valid_ff  <= 1'b1;
            hold_valid_ff <= res_valid;
         end else begin
            out_valid_ff  <= res_valid;
         end
      end else if (res_valid) begin
         hold_valid_ff <= 1'b1;
      end

      // payload
      if (out_free) begin
         if (hold_valid_ff) begin
            out_ff  <= hold_ff;
            hold_ff <= res;
         end else begin
            out_ff <= res;
         end
      end else if (res_valid) begin
         hold_ff <= res;
      end
   end

endmodule

`default_nettype wire

>>> rtl/cfpq_ctrl.sv
// Queue sequencer: head/count bookkeeping, feedback decision, RAM accesses.
`default_nettype none

module cfpq_ctrl
   import cfpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire cfpq_cfg_type                   cfg,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_mode,
   input  wire logic [15:0]                    req_tag,
   input  wire logic [15:0]                    req_bytes,
   input  wire logic                           hold_full,
   output logic                                res_valid,
   output cfpq_result_type                     res,
   output logic                                ram_wr_en,
   output logic      [$clog2(QUEUE_DEPTH)-1:0] ram_wr_addr,
   output cfpq_entry_type                      ram_wr_data,
   output logic                                ram_rd_en,
   output logic      [$clog2(QUEUE_DEPTH)-1:0] ram_rd_addr,
   input  wire cfpq_entry_type                 ram_rd_data
);

   localparam int AW    = $clog2(QUEUE_DEPTH);
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = (CW > 8) ? CW : 8;
   localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
   localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(QUEUE_DEPTH);
   localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FB_WR,
      ST_RD
   } state_type;

   state_type      state_ff, state_in;
   logic [AW-1:0]  head_ff, head_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           fb_active_ff, fb_active_in;
   logic           busy_ff, busy_in;
   logic [AW-1:0]  fb_addr_ff, fb_addr_in;
   cfpq_event_type fb_kind_ff, fb_kind_in;
   logic [8:0]     rd_occ_ff, rd_occ_in;

   logic [AW-1:0]  head_inc;
   logic [AW-1:0]  head_dec;
   logic [AW:0]    tail_sum;
   logic [AW-1:0]  tail_addr;
   logic [CMP_W-1:0] count_x;
   logic           drop;
   logic           fb_slow;
   logic           fb_resume;
   logic           fb_push;
   logic [CW-1:0]  count_push;
   logic           accept;

   assign head_inc  = (head_ff == LAST_ADDR) ? '0 : head_ff + AW'(1);
   assign head_dec  = (head_ff == '0) ? LAST_ADDR : head_ff - AW'(1);
   assign tail_sum  = {1'b0, head_ff} + (AW + 1)'(count_ff);
   assign tail_addr = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : tail_sum[AW-1:0];

   assign count_x   = CMP_W'(count_ff);
   assign drop      = (count_x >= CMP_W'(cfg.capacity)) || (count_ff >= FULL_CNT);
   assign fb_slow   = (count_x >= CMP_W'(cfg.high_mark)) && !fb_active_ff;
   assign fb_resume = !fb_slow && (count_x < CMP_W'(cfg.low_mark)) && fb_active_ff;
   assign fb_push   = fb_slow || fb_resume;
   assign count_push = count_ff + CW'(fb_push) + CW'(1);

   assign req_ready = (state_ff == ST_IDLE) && !hold_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      fb_active_in = fb_active_ff;
      busy_in      = busy_ff;
      fb_addr_in   = fb_addr_ff;
      fb_kind_in   = fb_kind_ff;
      rd_occ_in    = rd_occ_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = tail_addr;
      ram_wr_data = '{kind: EV_DATA, tag: req_tag, bytes: req_bytes};
      ram_rd_en   = 1'b0;
      ram_rd_addr = head_ff;

      res_valid = 1'b0;
      res       = '{event_res: EV_DATA, out_tag: req_tag, out_bytes: req_bytes,
                    occupancy: 9'(count_ff)};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_DONE) begin
                  if (count_ff == '0) begin
                     busy_in = 1'b0;
                  end else begin
                     ram_rd_en = 1'b1;
                     head_in   = head_inc;
                     count_in  = count_ff - CW'(1);
                     rd_occ_in = 9'(count_ff - CW'(1));
                     busy_in   = 1'b1;
                     state_in  = ST_RD;
                  end
               end else if (drop) begin
                  res_valid     = 1'b1;
                  res.event_res = EV_DROP;
               end else begin
                  if (fb_slow) begin
                     fb_active_in = 1'b1;
                  end else if (fb_resume) begin
                     fb_active_in = 1'b0;
                  end
                  fb_kind_in = fb_slow ? EV_SLOW : EV_RESUME;
                  ram_wr_en  = 1'b1;
                  if (!busy_ff) begin
                     // idle server: pop the new head at once
                     busy_in  = 1'b1;
                     count_in = count_push - CW'(1);
                     if (fb_push) begin
                        // feedback goes out immediately, no need to store it
                        res_valid = 1'b1;
                        res = '{event_res: fb_kind_in, out_tag: '0,
                                out_bytes: FEEDBACK_BYTES,
                                occupancy: 9'(count_push - CW'(1))};
                     end else if (count_ff == '0) begin
                        res_valid = 1'b1;
                        head_in   = head_inc;
                     end else begin
                        ram_rd_en = 1'b1;
                        head_in   = head_inc;
                        rd_occ_in = 9'(count_ff);
                        state_in  = ST_RD;
                     end
                  end else begin
                     count_in = count_push;
                     if (fb_push) begin
                        head_in    = head_dec;
                        fb_addr_in = head_dec;
                        state_in   = ST_FB_WR;
                     end
                  end
               end
            end
         end
         ST_FB_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = fb_addr_ff;
            ram_wr_data = '{kind: fb_kind_ff, tag: '0, bytes: FEEDBACK_BYTES};
            state_in    = ST_IDLE;
         end
         ST_RD: begin
            res_valid = 1'b1;
            res = '{event_res: ram_rd_data.kind, out_tag: ram_rd_data.tag,
                    out_bytes: ram_rd_data.bytes, occupancy: rd_occ_ff};
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         fb_active_ff <= 1'b0;
         busy_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         fb_active_ff <= fb_active_in;
         busy_ff      <= busy_in;
      end
      fb_addr_ff <= fb_addr_in;
      fb_kind_ff <= fb_kind_in;
      rd_occ_ff  <= rd_occ_in;
   end

endmodule

`default_nettype wire

>>> rtl/congestion_feedback_packet_queue_core.sv
// Packet descriptor queue with tail drop, xon/xoff feedback and a single server.
//
// Each word on req_ is a packet arrival (tuser 0) or a service completion
// (tuser 1). Arrivals are dropped once occupancy reaches capacity or
// QUEUE_DEPTH - 1, else a slow-down or resume feedback descriptor may be
// placed at the head before the packet joins the tail; an idle server sends
// the head at once. Every descriptor lives in one QUEUE_DEPTH x 34 bit RAM
// with a registered read. An item ends in the idle state when its result
// needs no RAM read (drops, feedback, arrivals into an empty queue, arrivals
// while busy without feedback); it passes through a read state when the RAM
// read of the popped head is in the path, or a write state when a feedback
// descriptor needs a second RAM write behind the tail write. Results pass
// through an output register and a one-word skid stage, so input flow
// continues while a result waits. No clearing pass is needed after reset.
`default_nettype none

module congestion_feedback_packet_queue_core
   import cfpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [31:0]            req_tdata,  // packet_tag[15:0], packet_bytes[31:16]
   input  wire logic                   req_tuser,  // mode
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [47:0]            rsp_tdata,  // out_tag[15:0], out_bytes[31:16],
                                                   // occupancy[40:32], zero[47:41]
   output logic      [1:0]             rsp_tuser,  // event_res
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]             csr_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);

   logic [7:0]      capacity_ff;
   logic [7:0]      high_mark_ff;
   logic [7:0]      low_mark_ff;
   cfpq_cfg_type    cfg;

   logic            hold_full;
   logic            res_valid;
   cfpq_result_type res;
   cfpq_result_type rsp;

   logic            ram_wr_en;
   logic [AW-1:0]   ram_wr_addr;
   cfpq_entry_type  ram_wr_data;
   logic            ram_rd_en;
   logic [AW-1:0]   ram_rd_addr;
   cfpq_entry_type  ram_rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         high_mark_ff <= HIGH_MARK_RESET;
         low_mark_ff  <= LOW_MARK_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CAPACITY:  capacity_ff  <= csr_data;
            CSR_HIGH_MARK: high_mark_ff <= csr_data;
            CSR_LOW_MARK:  low_mark_ff  <= csr_data;
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   assign cfg = '{capacity: capacity_ff, high_mark: high_mark_ff, low_mark: low_mark_ff};

   cfpq_ctrl #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_mode   (req_tuser),
      .req_tag    (req_tdata[15:0]),
      .req_bytes  (req_tdata[31:16]),
      .hold_full  (hold_full),
      .res_valid  (res_valid),
      .res        (res),
      .ram_wr_en  (ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data),
      .ram_rd_en  (ram_rd_en),
      .ram_rd_addr(ram_rd_addr),
      .ram_rd_data(ram_rd_data)
   );

   cfpq_ram #(
      .WIDTH($bits(cfpq_entry_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   cfpq_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .res_valid(res_valid),
      .res      (res),
      .hold_full(hold_full),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp      (rsp)
   );

   assign rsp_tuser = rsp.event_res;
   assign rsp_tdata = {7'd0, rsp.occupancy, rsp.out_bytes, rsp.out_tag};

`ifndef SYNTHESIS
   a_feedback_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_SLOW || rsp_tuser == EV_RESUME)
         |-> (rsp_tdata[15:0] == 16'd0) && (rsp_tdata[31:16] == FEEDBACK_BYTES))
      else $error("feedback word carries a tag or a wrong length");

   a_drop_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_DROP)
         |-> ({1'b0, capacity_ff} <= rsp_tdata[40:32])
             || (rsp_tdata[40:32] == 9'(QUEUE_DEPTH - 1)) || (QUEUE_DEPTH > 256))
      else $error("arrival dropped below the drop limit");

   a_quiet_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result word presented right after reset");
`endif

endmodule

`default_nettype wire

>>> test/cfpq_checker.sv
// Scoreboard for the packet queue core: predicts each result word and compares it.
`timescale 1ns / 100ps

module cfpq_checker
   import cfpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [31:0]            req_tdata,  // packet_tag[15:0], packet_bytes[31:16]
   input  logic                   req_tuser,  // mode
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [47:0]            rsp_tdata,  // out_tag[15:0], out_bytes[31:16],
                                              // occupancy[40:32], zero[47:41]
   input  logic [1:0]             rsp_tuser,  // event_res
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data,
   output int                     mismatch_count,
   output int                     outstanding
);

   localparam int REPORT_LIMIT = 10;

   cfpq_entry_type  slot_mem [QUEUE_DEPTH];
   int              head_ptr;
   int              used_count;
   bit              slowdown_on;
   bit              server_on;
   cfpq_cfg_type    cfg;
   cfpq_result_type expected_results [$];
   cfpq_result_type seen_result;
   cfpq_result_type oldest_result;

   initial mismatch_count = 0;
   initial outstanding = 0;

   task automatic note_mismatch(input string what, input cfpq_result_type want,
                                input cfpq_result_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: %s: expected ev/tag/bytes/occ %0d/%h/%h/%0d, got %0d/%h/%h/%0d",
                  $realtime, what, want.event_res, want.out_tag, want.out_bytes, want.occupancy,
                  got.event_res, got.out_tag, got.out_bytes, got.occupancy);
      end
   endtask

   // send the head entry and keep the server busy
   task automatic send_head();
      cfpq_result_type r;
      r.event_res = slot_mem[head_ptr].kind;
      r.out_tag   = slot_mem[head_ptr].tag;
      r.out_bytes = slot_mem[head_ptr].bytes;
      head_ptr    = (head_ptr + 1) % QUEUE_DEPTH;
      used_count--;
      r.occupancy = 9'(used_count);
      expected_results.push_back(r);
      server_on = 1'b1;
   endtask

   task automatic insert_feedback(input cfpq_event_type kind);
      head_ptr = (head_ptr == 0) ? QUEUE_DEPTH - 1 : head_ptr - 1;
      slot_mem[head_ptr] = '{kind: kind, tag: 16'h0000, bytes: FEEDBACK_BYTES};
      used_count++;
   endtask

   task automatic predict_queue_event(input logic mode, input logic [15:0] tag,
                                      input logic [15:0] bytes);
      cfpq_result_type r;
      if (mode == MODE_DONE) begin
         if (used_count == 0) begin
            server_on = 1'b0;
         end else begin
            send_head();
         end
      end else if (used_count >= int'(cfg.capacity) || used_count >= QUEUE_DEPTH - 1) begin
         r.event_res = EV_DROP;
         r.out_tag   = tag;
         r.out_bytes = bytes;
         r.occupancy = 9'(used_count);
         expected_results.push_back(r);
      end else begin
         if (used_count >= int'(cfg.high_mark) && !slowdown_on) begin
            insert_feedback(EV_SLOW);
            slowdown_on = 1'b1;
         end else if (used_count < int'(cfg.low_mark) && slowdown_on) begin
            insert_feedback(EV_RESUME);
            slowdown_on = 1'b0;
         end
         slot_mem[(head_ptr + used_count) % QUEUE_DEPTH] = '{kind: EV_DATA, tag: tag, bytes: bytes};
         used_count++;
         if (!server_on) begin
            send_head();
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         head_ptr      = 0;
         used_count    = 0;
         slowdown_on   = 1'b0;
         server_on     = 1'b0;
         cfg.capacity  = CAPACITY_RESET;
         cfg.high_mark = HIGH_MARK_RESET;
         cfg.low_mark  = LOW_MARK_RESET;
         expected_results.delete();
      end else begin
         // results leaving now belong to words accepted at earlier edges
         if (rsp_tvalid && rsp_tready) begin
            seen_result.event_res = cfpq_event_type'(rsp_tuser);
            seen_result.out_tag   = rsp_tdata[15:0];
            seen_result.out_bytes = rsp_tdata[31:16];
            seen_result.occupancy = rsp_tdata[40:32];
            if (expected_results.size() == 0) begin
               note_mismatch("result word with nothing expected", '0, seen_result);
            end else begin
               oldest_result = expected_results.pop_front();
               if (seen_result.event_res !== oldest_result.event_res ||
                   seen_result.out_tag   !== oldest_result.out_tag   ||
                   seen_result.out_bytes !== oldest_result.out_bytes ||
                   seen_result.occupancy !== oldest_result.occupancy) begin
                  note_mismatch("result word differs", oldest_result, seen_result);
               end
            end
         end
         // a word accepted at this edge still sees the old settings
         if (req_tvalid && req_tready) begin
            predict_queue_event(req_tuser, req_tdata[15:0], req_tdata[31:16]);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CAPACITY:  cfg.capacity  = csr_data;
               CSR_HIGH_MARK: cfg.high_mark = csr_data;
               CSR_LOW_MARK:  cfg.low_mark  = csr_data;
               default: ;
            endcase
         end
      end
      outstanding = expected_results.size();
   end

endmodule

>>> test/tb_congestion_feedback_packet_queue_core.sv
// Top of the packet queue core testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_congestion_feedback_packet_queue_core
   import cfpq_pkg::*;
;

   localparam int RESET_CYCLES  = 11;
   localparam int QUIET_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 600;
   localparam int SETTLE_CYCLES = 10;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [31:0]            req_tdata  = '0;  // packet_tag[15:0], packet_bytes[31:16]
   logic                   req_tuser  = 1'b0; // mode
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [47:0]            rsp_tdata;        // out_tag[15:0], out_bytes[31:16],
                                             // occupancy[40:32], zero[47:41]
   logic [1:0]             rsp_tuser;        // event_res
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [7:0]             csr_data   = '0;

   int mismatch_count;
   int outstanding;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   always #4 clock = ~clock;

   congestion_feedback_packet_queue_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   cfpq_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // result side: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: watchdog expired with %0d results outstanding", $realtime, outstanding);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [15:0] rand_word();
      case ($urandom_range(7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // leaves req_tvalid high; the next call or settle_block decides what follows
   task automatic send_item(input logic mode, input logic [15:0] tag, input logic [15:0] bytes);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {bytes, tag};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr_word(input logic [CSR_INDEX_W-1:0] index, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic apply_config(input logic [7:0] cap, input logic [7:0] hi, input logic [7:0] lo);
      write_csr_word(CSR_CAPACITY, cap);
      write_csr_word(CSR_HIGH_MARK, hi);
      write_csr_word(CSR_LOW_MARK, lo);
      csr_valid <= 1'b0;
   endtask

   // drop valid, wait for every expected word, then let silent items finish
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      int         seg;
      int         n;
      int         seg_items;
      int         burst_left;
      int         arrive_pct;
      bit         fill_first;
      logic [7:0] cap;
      logic [7:0] hi;
      logic [7:0] lo;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset marks: idle completion, arrivals into empty and busy server
      send_item(MODE_DONE, 16'hA5A5, 16'h5A5A);
      send_item(MODE_ARRIVAL, 16'h0000, 16'h0000);
      send_item(MODE_ARRIVAL, 16'hFFFF, 16'hFFFF);
      send_item(MODE_ARRIVAL, 16'h1234, 16'h0001);
      send_item(MODE_DONE, 16'h0000, 16'h0000);
      send_item(MODE_DONE, 16'h0000, 16'h0000);
      send_item(MODE_DONE, 16'h0000, 16'h0000);
      settle_block();

      // tiny queue: slow-down, tail drop, then resume
      apply_config(8'd3, 8'd1, 8'd2);
      send_item(MODE_ARRIVAL, 16'h0101, 16'h0040);
      send_item(MODE_ARRIVAL, 16'h0202, 16'h0080);
      send_item(MODE_ARRIVAL, 16'h0303, 16'h0100);
      send_item(MODE_ARRIVAL, 16'h0404, 16'h0200);
      send_item(MODE_DONE, 16'h0000, 16'h0000);
      send_item(MODE_DONE, 16'h0000, 16'h0000);
      send_item(MODE_ARRIVAL, 16'h0505, 16'h0400);
      repeat (4) send_item(MODE_DONE, 16'h0000, 16'h0000);
      settle_block();

      // slow-down into an empty queue
      apply_config(8'd3, 8'd0, 8'd0);
      send_item(MODE_ARRIVAL, 16'h0606, 16'h0800);
      send_item(MODE_DONE, 16'h0000, 16'h0000);
      send_item(MODE_DONE, 16'h0000, 16'h0000);
      settle_block();

      // zero capacity drops everything
      apply_config(8'd0, HIGH_MARK_RESET, LOW_MARK_RESET);
      send_item(MODE_ARRIVAL, 16'h0707, 16'h1000);

      for (seg = 0; seg < 9; seg++) begin
         fill_first = 1'b0;
         case (seg)
            0: begin cap = 8'd255; hi = 8'd204; lo = 8'd63;  seg_items = 300; fill_first = 1'b1; end
            1: begin cap = 8'd8;   hi = 8'd5;   lo = 8'd2;   seg_items = 100; end
            2: begin cap = 8'd255; hi = 8'd255; lo = 8'd0;   seg_items = 100; end
            3: begin cap = 8'd1;   hi = 8'd0;   lo = 8'd0;   seg_items = 100; end
            4: begin cap = 8'd0;   hi = 8'd0;   lo = 8'd255; seg_items = 80;  end
            5: begin cap = 8'd16;  hi = 8'd12;  lo = 8'd4;   seg_items = 120; end
            6: begin cap = 8'd255; hi = 8'd0;   lo = 8'd255; seg_items = 100; end
            7: begin cap = 8'd4;   hi = 8'd2;   lo = 8'd1;   seg_items = 100; end
            default: begin cap = 8'd40; hi = 8'd30; lo = 8'd10; seg_items = 280; end
         endcase
         settle_block();
         apply_config(cap, hi, lo);
         if (seg < 3) begin
            send_idle_pct = 26;
            recv_idle_pct = 79;
         end else if (seg < 6) begin
            send_idle_pct = 79;
            recv_idle_pct = 26;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         burst_left = 0;
         for (n = 0; n < seg_items; n++) begin
            if (seg == 3 && n == 40) hold_requests++;
            if (seg == 5 && n == 60) settle_block();
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 30);
               case ($urandom_range(2))
                  0:       arrive_pct = 90;
                  1:       arrive_pct = 50;
                  default: arrive_pct = 10;
               endcase
            end
            burst_left--;
            // push the big queue up to the drop point before mixing
            if (fill_first && n < 260) arrive_pct = 99;
            send_item(($urandom_range(99) < arrive_pct) ? MODE_ARRIVAL : MODE_DONE,
                      rand_word(), rand_word());
         end
      end

      settle_block();
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
